// ===== hdl/tcms_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the ternary cube match scorer.
// No dependencies; used by tcms_ctrl, tcms_dpath and the top level.
package tcms_pkg;

    // Input positions in use and output value bits carried by the block.
    localparam int NIN       = 16;
    localparam int NOUT      = 8;
    localparam int CUBES_DEF = 64;

    localparam int         IN_LIM   = (NIN < 16) ? NIN : 16;
    localparam logic [7:0] VAL_MASK = (NOUT >= 8) ? 8'hFF : 8'((1 << NOUT) - 1);

    localparam logic [4:0] ACTIVE_RST = 5'd16;

    // Item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CONFLICT = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [15:0] care;
        logic [15:0] bits;
        logic [7:0]  value;
    } t_cube;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic rd_issue;
        logic finish;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic rd_done;
        logic out_free;
    } t_sts;

    // Mask of the active input positions; 0 counts as 1, clamp at the limit.
    function automatic logic [15:0] active_mask(input logic [4:0] act);
        logic [4:0]  n;
        logic [15:0] m;
        n = act;
        if (n == 5'd0) begin
            n = 5'd1;
        end
        if (n > 5'(IN_LIM)) begin
            n = 5'(IN_LIM);
        end
        for (int p = 0; p < 16; p++) begin
            m[p] = (5'(p) < n);
        end
        return m;
    endfunction

endpackage

// ===== hdl/tcms_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine for the ternary cube match scorer.
// Depends on tcms_pkg; drives the load, scan and finish commands of tcms_dpath.
module tcms_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  tcms_pkg::t_sts i_sts,
    output tcms_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import tcms_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                // one table entry read per cycle; last compare lands as we leave
                if (!i_sts.rd_done) begin
                    o_cmd.rd_issue = 1'b1;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_sts.out_free)
        else $error("finish issued while output register busy");

endmodule

// ===== hdl/tcms_dpath.sv =====
`timescale 1ns / 1ps
// Datapath of the ternary cube match scorer: cube table memory, scan compare,
// counters, configuration register and output register. Depends on tcms_pkg.
module tcms_dpath #(
    parameter int CUBES = tcms_pkg::CUBES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tcms_pkg::t_cmd i_cmd,
    output tcms_pkg::t_sts o_sts,
    input  logic           i_cfg_wen,
    input  logic [4:0]     i_cfg_wdata,
    input  logic           i_kind,
    input  logic [15:0]    i_care_mask,
    input  logic [15:0]    i_pattern_bits,
    input  logic [7:0]     i_value,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [1:0]     o_status,
    output logic [7:0]     o_found_value,
    output logic           o_agree,
    output logic [15:0]    o_agree_count,
    output logic [15:0]    o_query_count
);
    import tcms_pkg::*;

    localparam int AW = $clog2(CUBES);
    localparam int CW = $clog2(CUBES + 1);

    t_cube mem [CUBES];

    // control state
    logic [4:0]    r_active;
    logic [CW-1:0] r_used;
    logic [CW-1:0] r_idx;
    logic          r_rd_vld;
    logic          r_hit;
    logic          r_out_valid;
    logic [15:0]   r_agree_total;
    logic [15:0]   r_query_total;

    // item and scan payload
    logic          r_kind;
    logic [15:0]   r_am;
    logic [15:0]   r_care;
    logic [15:0]   r_bits;
    logic [7:0]    r_val;
    t_cube         r_rd_data;
    logic          r_conflict;
    logic [15:0]   r_best;
    logic [7:0]    r_found;

    logic [1:0]    r_out_status;
    logic [7:0]    r_out_found;
    logic          r_out_agree;

    logic [15:0]   am_in;
    logic [15:0]   care_in;
    logic [15:0]   c_ent;
    logic          match_q;
    logic          match_l;
    logic          full;

    logic [1:0]    n_status;
    logic [7:0]    n_found;
    logic          n_agree;
    logic          wr_en;
    logic [15:0]   n_agree_total;
    logic [15:0]   n_query_total;

    assign am_in   = active_mask(r_active);
    assign care_in = i_care_mask & am_in;

    assign c_ent   = r_rd_data.care & r_am;
    assign match_q = ((r_rd_data.bits ^ r_bits) & c_ent) == 16'd0;
    assign match_l = (r_rd_data.care == r_care) && (r_rd_data.bits == r_bits);
    assign full    = (r_used == CW'(CUBES));

    assign o_sts.rd_done  = (r_idx == r_used);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_status      = ST_OK;
        n_found       = 8'd0;
        n_agree       = 1'b0;
        wr_en         = 1'b0;
        n_agree_total = r_agree_total;
        n_query_total = r_query_total;
        if (r_kind == KIND_LOAD) begin
            if (r_val == 8'd0) begin
                n_status = ST_ZERO;
            end else if (r_hit) begin
                n_status = r_conflict ? ST_CONFLICT : ST_OK;
            end else if (full) begin
                n_status = ST_FULL;
            end else begin
                wr_en = 1'b1;
            end
        end else begin
            n_found = r_hit ? r_found : 8'd0;
            n_agree = (n_found == r_val);
            if (r_query_total != 16'hFFFF) begin
                n_query_total = r_query_total + 16'd1;
            end
            if (n_agree && (r_agree_total != 16'hFFFF)) begin
                n_agree_total = r_agree_total + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active      <= ACTIVE_RST;
            r_used        <= '0;
            r_idx         <= '0;
            r_rd_vld      <= 1'b0;
            r_hit         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_agree_total <= '0;
            r_query_total <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_active <= i_cfg_wdata;
            end
            r_rd_vld <= i_cmd.rd_issue;
            if (i_cmd.load_item) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.rd_issue) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_rd_vld) begin
                    if (r_kind == KIND_LOAD) begin
                        if (match_l) begin
                            r_hit <= 1'b1;
                        end
                    end else if (match_q) begin
                        r_hit <= 1'b1;
                    end
                end
            end
            if (i_cmd.finish) begin
                r_out_valid   <= 1'b1;
                r_agree_total <= n_agree_total;
                r_query_total <= n_query_total;
                if (wr_en) begin
                    r_used <= r_used + CW'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind     <= i_kind;
            r_am       <= am_in;
            r_care     <= care_in;
            r_val      <= i_value & VAL_MASK;
            // query keeps the pattern; a load keeps only its fixed bits
            r_bits     <= (i_kind == KIND_LOAD) ? (i_pattern_bits & care_in)
                                                : (i_pattern_bits & am_in);
            r_conflict <= 1'b0;
            r_best     <= '0;
            r_found    <= '0;
        end else if (r_rd_vld) begin
            if (r_kind == KIND_LOAD) begin
                // first identical cube decides
                if (!r_hit && match_l) begin
                    r_conflict <= (r_rd_data.value != r_val);
                end
            end else if (match_q && (!r_hit || (c_ent > r_best))) begin
                r_best  <= c_ent;
                r_found <= r_rd_data.value;
            end
        end
        if (i_cmd.finish) begin
            r_out_status <= n_status;
            r_out_found  <= n_found;
            r_out_agree  <= n_agree;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
        if (i_cmd.finish && wr_en) begin
            mem[r_used[AW-1:0]] <= '{care: r_care, bits: r_bits, value: r_val};
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_found;
    assign o_agree       = r_out_agree;
    assign o_agree_count = r_agree_total;
    assign o_query_count = r_query_total;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_used)
        else $error("scan index beyond table fill");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(CUBES))
        else $error("table fill count beyond depth");

    a_agree_le_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_agree_total <= r_query_total)
        else $error("agree count exceeds query count");

endmodule

// ===== hdl/ternary_cube_match_scorer_unit.sv =====
`timescale 1ns / 1ps
// Ternary cube match scorer, top level.
// Input channel (i_in_valid / o_in_stall) carries load and query items: a load
// stores a cube (care mask, fixed bits, value) in the table, a query looks up
// the highest-priority matching cube for a pattern and scores it against the
// expected value. Output channel (o_out_valid / i_out_stall) returns one
// result item per input item. i_cfg_wen / i_cfg_wdata set the active input
// count; write it only while the block is idle.
// An item is scanned against every cube currently stored (up to CUBES): the
// scan reads one table entry per cycle through the single memory read port.
// The next item is accepted in the cycle after the result is loaded, so the
// block does not take a new item before it is through with the last one.
// A result waiting in the output register does not block acceptance of the
// next item; only when a finished result finds the register still stalled
// does the block hold it, and new input stalls until the register frees.
// Reset empties the table, clears both counters and sets the active count
// to 16; no clearing pass runs.
// Depends on tcms_pkg, tcms_ctrl and tcms_dpath.
module ternary_cube_match_scorer_unit #(
    parameter int CUBES = tcms_pkg::CUBES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [15:0] i_care_mask,
    input  logic [15:0] i_pattern_bits,
    input  logic [7:0]  i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [7:0]  o_found_value,
    output logic        o_agree,
    output logic [15:0] o_agree_count,
    output logic [15:0] o_query_count
);
    import tcms_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tcms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tcms_dpath #(
        .CUBES (CUBES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_kind         (i_kind),
        .i_care_mask    (i_care_mask),
        .i_pattern_bits (i_pattern_bits),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found_value  (o_found_value),
        .o_agree        (o_agree),
        .o_agree_count  (o_agree_count),
        .o_query_count  (o_query_count)
    );

endmodule

// ===== tb/sv/ternary_cube_match_scorer_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for ternary_cube_match_scorer_unit: a queue-fed driver, a monitor that
// predicts every result from its own copy of the cube table, and phased stall patterns.
// Depends on tcms_pkg and the ternary_cube_match_scorer_unit RTL.
module ternary_cube_match_scorer_unit_tb;
    import tcms_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int          TBL_DEPTH    = CUBES_DEF;
    localparam int          DRAIN_WAIT   = TBL_DEPTH + 8;
    localparam int unsigned CYCLE_LIMIT  = 5000000;
    localparam int          MAX_REPORTS  = 10;

    typedef struct packed {
        logic        kind;
        logic [15:0] care;
        logic [15:0] bits;
        logic [7:0]  value;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  found;
        logic        agree;
        logic [15:0] agree_cnt;
        logic [15:0] query_cnt;
    } t_score;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_cfg_wen      = 1'b0;
    logic [4:0]  i_cfg_wdata    = 5'd0;
    logic        i_in_valid     = 1'b0;
    logic        i_kind         = KIND_LOAD;
    logic [15:0] i_care_mask    = 16'd0;
    logic [15:0] i_pattern_bits = 16'd0;
    logic [7:0]  i_value        = 8'd0;
    logic        i_out_stall    = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [7:0]  o_found_value;
    logic        o_agree;
    logic [15:0] o_agree_count;
    logic [15:0] o_query_count;

    // Predicted copy of the block state.
    logic [15:0] tbl_care  [TBL_DEPTH];
    logic [15:0] tbl_bits  [TBL_DEPTH];
    logic [7:0]  tbl_value [TBL_DEPTH];
    int          tbl_fill    = 0;
    logic [15:0] agree_tally = 16'd0;
    logic [15:0] query_tally = 16'd0;
    logic [4:0]  active_sel  = ACTIVE_RST;

    t_item       queued_items [$];
    t_item       cube_hist    [$];
    t_score      owed_results [$];
    int          n_open        = 0;
    int          err_count     = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned send_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int          hold_off_left = 0;
    logic        in_taken      = 1'b0;

    ternary_cube_match_scorer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_care_mask    (i_care_mask),
        .i_pattern_bits (i_pattern_bits),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_found_value  (o_found_value),
        .o_agree        (o_agree),
        .o_agree_count  (o_agree_count),
        .o_query_count  (o_query_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic [15:0] pos_mask(input logic [4:0] sel);
        int n;
        n = (sel == 5'd0) ? 1 : int'(sel);
        if (n > IN_LIM) begin
            n = IN_LIM;
        end
        return (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 32'd1);
    endfunction

    // Apply one item to the predicted table and counters, return its result.
    function automatic t_score match_and_score(input t_item it);
        t_score      res;
        logic [15:0] am;
        logic [15:0] care;
        logic [15:0] bits;
        logic [15:0] c;
        logic [15:0] best;
        logic [7:0]  val;
        logic        dup;
        logic        have;
        am   = pos_mask(active_sel);
        care = it.care & am;
        bits = it.bits & am;
        val  = it.value & VAL_MASK;
        res  = '0;
        if (it.kind == KIND_LOAD) begin
            bits = bits & care;
            res.status = ST_OK;
            if (val == 8'd0) begin
                res.status = ST_ZERO;
            end else begin
                dup = 1'b0;
                for (int i = 0; i < tbl_fill; i++) begin
                    if (!dup && tbl_care[i] == care && tbl_bits[i] == bits) begin
                        dup = 1'b1;
                        if (tbl_value[i] != val) begin
                            res.status = ST_CONFLICT;
                        end
                    end
                end
                if (!dup) begin
                    if (tbl_fill >= TBL_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        tbl_care[tbl_fill]  = care;
                        tbl_bits[tbl_fill]  = bits;
                        tbl_value[tbl_fill] = val;
                        tbl_fill++;
                    end
                end
            end
        end else begin
            have = 1'b0;
            best = 16'd0;
            for (int i = 0; i < tbl_fill; i++) begin
                c = tbl_care[i] & am;
                // strictly larger care wins, so the lower index keeps a tie
                if (((tbl_bits[i] ^ bits) & c) == 16'd0 && (!have || c > best)) begin
                    have      = 1'b1;
                    best      = c;
                    res.found = tbl_value[i];
                end
            end
            res.agree = (res.found == val);
            if (query_tally != 16'hFFFF) begin
                query_tally++;
            end
            if (res.agree && agree_tally != 16'hFFFF) begin
                agree_tally++;
            end
        end
        res.agree_cnt = agree_tally;
        res.query_cnt = query_tally;
        return res;
    endfunction

    function automatic t_item rand_item();
        t_item it;
        t_item h;
        it.care  = 16'($urandom);
        it.bits  = 16'($urandom);
        it.value = 8'($urandom);
        if ($urandom_range(99) < 45) begin
            it.kind = KIND_LOAD;
            // favor sparse care masks so queries hit several cubes
            case ($urandom_range(2))
                0: it.care = it.care & 16'($urandom) & 16'($urandom);
                1: it.care = it.care & 16'($urandom);
                default: ;
            endcase
            if (cube_hist.size() != 0 && $urandom_range(99) < 30) begin
                h       = cube_hist[$urandom_range(cube_hist.size() - 1)];
                it.care = h.care;
                it.bits = h.bits;
                if ($urandom_range(1) == 0) begin
                    it.value = h.value;
                end
            end
            if ($urandom_range(99) < 5) begin
                it.value = 8'd0;
            end
            cube_hist.insert(cube_hist.size(), it);
        end else begin
            it.kind = KIND_QUERY;
            if (cube_hist.size() != 0 && $urandom_range(99) < 60) begin
                // steer the pattern onto a known cube
                h       = cube_hist[$urandom_range(cube_hist.size() - 1)];
                it.bits = (h.bits & h.care) | (it.bits & ~h.care);
                if ($urandom_range(1) == 0) begin
                    it.value = h.value;
                end
            end else if ($urandom_range(1) == 0) begin
                it.value = 8'd0;
            end
        end
        return it;
    endfunction

    task automatic push_item(input logic kind, input logic [15:0] care,
                             input logic [15:0] bits, input logic [7:0] value);
        t_item it;
        it.kind  = kind;
        it.care  = care;
        it.bits  = bits;
        it.value = value;
        queued_items.insert(queued_items.size(), it);
        n_open++;
    endtask

    task automatic wait_drained();
        while (n_open != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_active(input logic [4:0] n);
        wait_drained();
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= n;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        active_sel   = n;
    endtask

    task automatic run_phase(input int unsigned send_pct, input int unsigned stall_pct,
                             input int n);
        t_item it;
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
        for (int k = 0; k < n; k++) begin
            // hold the sender until the block is empty halfway through
            if (k == n / 2) begin
                wait_drained();
            end
            it = rand_item();
            push_item(it.kind, it.care, it.bits, it.value);
        end
        wait_drained();
    endtask

    // Present the next item once the current one is taken.
    always @(negedge i_clk) begin : drive_items
        t_item nxt;
        if (!i_in_valid || in_taken) begin
            if (queued_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt             = queued_items.pop_front();
                i_in_valid     <= 1'b1;
                i_kind         <= nxt.kind;
                i_care_mask    <= nxt.care;
                i_pattern_bits <= nxt.bits;
                i_value        <= nxt.value;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off_left != 0) begin
            hold_off_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch_results
        t_item  acc;
        t_score want;
        t_score got;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) begin
            acc.kind  = i_kind;
            acc.care  = i_care_mask;
            acc.bits  = i_pattern_bits;
            acc.value = i_value;
            owed_results.insert(owed_results.size(), match_and_score(acc));
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status    = o_status;
            got.found     = o_found_value;
            got.agree     = o_agree;
            got.agree_cnt = o_agree_count;
            got.query_cnt = o_query_count;
            if (owed_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result st=%0d fv=%02h ag=%0b ac=%0d qc=%0d",
                             $time, got.status, got.found, got.agree, got.agree_cnt,
                             got.query_cnt);
                end
            end else begin
                want = owed_results.pop_front();
                n_open--;
                if (got.status !== want.status || got.found !== want.found ||
                    got.agree !== want.agree || got.agree_cnt !== want.agree_cnt ||
                    got.query_cnt !== want.query_cnt) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("%0t: mismatch exp st=%0d fv=%02h ag=%0b ac=%0d qc=%0d",
                                 $time, want.status, want.found, want.agree,
                                 want.agree_cnt, want.query_cnt);
                        $display("%0t:          got st=%0d fv=%02h ag=%0b ac=%0d qc=%0d",
                                 $time, got.status, got.found, got.agree,
                                 got.agree_cnt, got.query_cnt);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_active(5'd16);

        // Extremes, merge, conflict, masking and priority between cubes.
        push_item(KIND_LOAD,  16'hFFFF, 16'h1234, 8'h00);
        push_item(KIND_QUERY, 16'h0000, 16'h0000, 8'h00);
        push_item(KIND_LOAD,  16'h0000, 16'hFFFF, 8'h01);
        push_item(KIND_LOAD,  16'hFFFF, 16'hFFFF, 8'hFF);
        push_item(KIND_LOAD,  16'hFFFF, 16'h0000, 8'h80);
        push_item(KIND_LOAD,  16'h8000, 16'h8000, 8'h11);
        push_item(KIND_LOAD,  16'h0001, 16'h0001, 8'h22);
        push_item(KIND_LOAD,  16'hFFFF, 16'hFFFF, 8'hFF);
        push_item(KIND_LOAD,  16'hFFFF, 16'hFFFF, 8'h7F);
        push_item(KIND_LOAD,  16'h0000, 16'h1234, 8'h01);
        push_item(KIND_LOAD,  16'h0000, 16'h0000, 8'h02);
        push_item(KIND_QUERY, 16'hFFFF, 16'hFFFF, 8'hFF);
        push_item(KIND_QUERY, 16'h0000, 16'h0000, 8'h80);
        push_item(KIND_QUERY, 16'h0000, 16'h8001, 8'h11);
        push_item(KIND_QUERY, 16'hFFFF, 16'h0001, 8'h00);
        push_item(KIND_QUERY, 16'h0000, 16'h4000, 8'h01);
        push_item(KIND_QUERY, 16'h0000, 16'h8000, 8'h11);
        push_item(KIND_LOAD,  16'h5555, 16'hAAAA, 8'hAA);
        push_item(KIND_QUERY, 16'h0000, 16'hAAAA, 8'hAA);
        push_item(KIND_LOAD,  16'hAAAA, 16'hFFFF, 8'h55);
        push_item(KIND_QUERY, 16'h0000, 16'hFFFF, 8'h55);
        wait_drained();

        run_phase(0, 0, 250);
        write_active(5'd31);
        run_phase(84, 0, 240);
        write_active(5'($urandom_range(15, 2)));
        run_phase(0, 84, 240);
        write_active(5'd0);
        run_phase(11, 11, 240);
        write_active(5'd1);
        run_phase(0, 0, 240);
        write_active(5'd16);
        // Hold the receiver off so results back up into the input channel.
        hold_off_left = 600;
        run_phase(0, 0, 240);
        write_active(5'($urandom_range(31, 17)));
        run_phase(0, 84, 240);
        write_active(5'($urandom_range(15, 2)));
        run_phase(11, 11, 240);

        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (err_count == 0 && owed_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
